[rtl/rra_pkg.sv]
// ----------------------------------------------------------------------------
// rra_pkg
// Shared widths, item type and award codes for the relative rank assigner.
// ----------------------------------------------------------------------------
package rra_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int SCORE_W      = 32;
   localparam int RANK_W       = 7;
   localparam int AWARD_W      = 2;
   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);
   localparam int GRP_SIZE     = 8;
   localparam int GRP_W        = $clog2(GRP_SIZE + 1);

   typedef enum logic [AWARD_W-1:0] {
      AWARD_NONE   = 2'd0,
      AWARD_GOLD   = 2'd1,
      AWARD_SILVER = 2'd2,
      AWARD_BRONZE = 2'd3
   } award_type;

   // one classified input item
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      last;
      logic                      drop;
   } item_type;

   function automatic award_type award_of(input logic [RANK_W-1:0] rank);
      award_type aw;
      case (rank)
         RANK_W'(1): aw = AWARD_GOLD;
         RANK_W'(2): aw = AWARD_SILVER;
         RANK_W'(3): aw = AWARD_BRONZE;
         default:    aw = AWARD_NONE;
      endcase
      return aw;
   endfunction

endpackage

[rtl/rra_front.sv]
// ----------------------------------------------------------------------------
// rra_front
// Accepts scores and marks those that arrive after the store is full.
// ----------------------------------------------------------------------------
module rra_front #(
   parameter int CAPACITY = rra_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [rra_pkg::SCORE_W-1:0] req_score,
   input  logic                               req_last,
   output logic                               push,
   output rra_pkg::item_type                  push_item,
   input  logic                               q_full
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;
   assign drop      = (count_ff == CNT_W'(CAPACITY));

   assign push_item.score = req_score;
   assign push_item.last  = req_last;
   assign push_item.drop  = drop;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_last) begin
            count_in = '0;
         end else if (!drop) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[rtl/rra_queue.sv]
// ----------------------------------------------------------------------------
// rra_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rra_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rra_pkg::item_type push_item,
   output logic              full,
   output logic              q_valid,
   output rra_pkg::item_type q_item,
   input  logic              pop
);
   localparam int PW = rra_pkg::Q_PTR_W;
   localparam int CW = $clog2(rra_pkg::Q_DEPTH + 1);

   rra_pkg::item_type slot_ff [rra_pkg::Q_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign full    = (count_ff == CW'(rra_pkg::Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item pushed into full queue");

endmodule

[rtl/rra_back.sv]
// ----------------------------------------------------------------------------
// rra_back
// Rank cells: compare each arrival against stored scores, count, and emit.
// ----------------------------------------------------------------------------
module rra_back #(
   parameter int CAPACITY = rra_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  rra_pkg::item_type                 q_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rra_pkg::RANK_W-1:0]        rsp_rank,
   output logic [rra_pkg::AWARD_W-1:0]       rsp_award,
   output logic                              rsp_final_result,
   output logic                              rsp_truncated
);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int NGRP   = (CAPACITY + rra_pkg::GRP_SIZE - 1) / rra_pkg::GRP_SIZE;
   localparam int RANK_W = rra_pkg::RANK_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic signed [rra_pkg::SCORE_W-1:0] key_ff;
   logic                              last_ff;
   logic signed [rra_pkg::SCORE_W-1:0] score_ff [CAPACITY];
   logic [CNT_W-1:0]                  rank_ff  [CAPACITY];
   logic [CAPACITY-1:0]               ge_ff, ge_in;
   logic [rra_pkg::GRP_W-1:0]         grp_ff [NGRP];
   logic [rra_pkg::GRP_W-1:0]         grp_in [NGRP];
   logic [CNT_W-1:0]                  fill_ff, fill_in;
   logic                              ovf_ff, ovf_in;
   logic [CNT_W-1:0]                  emit_cnt_ff, emit_cnt_in;
   logic [CNT_W:0]                    total;
   logic                              load;
   logic                              emit_last;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]                 rsp_rank_ff;
   rra_pkg::award_type                rsp_award_ff;
   logic                              rsp_final_ff, rsp_trunc_ff;

   assign pop       = (state_ff == ST_IDLE);
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = (emit_cnt_ff == fill_ff - CNT_W'(1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_award        = rsp_award_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_truncated    = rsp_trunc_ff;

   // compare the arrival against every occupied cell
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         ge_in[k] = (fill_ff > CNT_W'(k)) && (score_ff[k] >= key_ff);
      end
   end

   // first level of the count tree: one popcount per group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < rra_pkg::GRP_SIZE; j++) begin
            if (g * rra_pkg::GRP_SIZE + j < CAPACITY) begin
               grp_in[g] = grp_in[g]
                         + rra_pkg::GRP_W'(ge_ff[g * rra_pkg::GRP_SIZE + j]);
            end
         end
      end
   end

   // second level: add the groups, plus one for the arrival itself
   always_comb begin
      total = (CNT_W + 1)'(1);
      for (int g = 0; g < NGRP; g++) begin
         total = total + (CNT_W + 1)'(grp_ff[g]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      emit_cnt_in = emit_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.drop) begin
                  ovf_in   = 1'b1;
                  state_in = q_item.last ? ST_EMIT : ST_IDLE;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: state_in = ST_SUM;
         ST_SUM: state_in = ST_ADD;
         ST_ADD: begin
            fill_in  = fill_ff + CNT_W'(1);
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (load) begin
               emit_cnt_in = emit_cnt_ff + CNT_W'(1);
               if (emit_last) begin
                  fill_in     = '0;
                  ovf_in      = 1'b0;
                  emit_cnt_in = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         key_ff  <= q_item.score;
         last_ff <= q_item.last;
      end
      if (state_ff == ST_CMP) begin
         ge_ff <= ge_in;
      end
      if (state_ff == ST_SUM) begin
         grp_ff <= grp_in;
      end
      if (load) begin
         rsp_rank_ff  <= RANK_W'(rank_ff[0]);
         rsp_award_ff <= rra_pkg::award_of(RANK_W'(rank_ff[0]));
         rsp_final_ff <= emit_last;
         rsp_trunc_ff <= ovf_ff;
      end
   end

   // one cell per stored score
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [CNT_W-1:0] next_rank;
      if (k + 1 < CAPACITY) begin : g_shift
         assign next_rank = rank_ff[k + 1];
      end else begin : g_end
         assign next_rank = rank_ff[k];
      end

      always_ff @(posedge clock) begin
         case (state_ff)
            ST_CMP: begin
               // bump the rank of every occupied cell not above the arrival
               if (fill_ff > CNT_W'(k) && score_ff[k] <= key_ff) begin
                  rank_ff[k] <= rank_ff[k] + CNT_W'(1);
               end
            end
            ST_ADD: begin
               if (fill_ff == CNT_W'(k)) begin
                  score_ff[k] <= key_ff;
                  rank_ff[k]  <= CNT_W'(total);
               end
            end
            ST_EMIT: begin
               // advance the ranks toward cell zero, one per result
               if (load) begin
                  rank_ff[k] <= next_rank;
               end
            end
            default: begin
            end
         endcase
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rank_ff != '0) && (rsp_rank_ff <= RANK_W'(CAPACITY)))
      else $error("emitted rank out of range");

   a_list_close: assert property (@(posedge clock) disable iff (reset)
      load && emit_last |=> (fill_ff == '0) && !ovf_ff)
      else $error("list state not cleared after final result");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> fill_ff != '0)
      else $error("emitting an empty list");

endmodule

[rtl/relative_rank_assigner.sv]
// ----------------------------------------------------------------------------
// relative_rank_assigner
// Descending rank assignment with gold, silver and bronze award codes.
// ----------------------------------------------------------------------------
// Scores arrive one per item; the item with req_last closes the list and the
// block then returns one result per stored score, in arrival order, giving
// its rank (count of stored scores greater than or equal to it) and award.
// A two-entry queue takes input items while the rank cells are busy. Each
// stored score goes through the cells in order: pop, a parallel compare
// across all cells, then a two-level registered count tree that yields
// the new score's rank. A score past CAPACITY is dropped and sets
// rsp_truncated on the list's results. Results leave at one per cycle
// while rsp_ready is high; the next list's items queue up meanwhile.
module relative_rank_assigner #(
   parameter int CAPACITY = rra_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [rra_pkg::SCORE_W-1:0] req_score,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rra_pkg::RANK_W-1:0]         rsp_rank,
   output logic [rra_pkg::AWARD_W-1:0]        rsp_award,
   output logic                               rsp_final_result,
   output logic                               rsp_truncated
);
   logic              push;
   rra_pkg::item_type push_item;
   logic              q_full;
   logic              q_valid;
   rra_pkg::item_type q_item;
   logic              pop;

   rra_front #(.CAPACITY(CAPACITY)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_score (req_score),
      .req_last  (req_last),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   rra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop)
   );

   rra_back #(.CAPACITY(CAPACITY)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank         (rsp_rank),
      .rsp_award        (rsp_award),
      .rsp_final_result (rsp_final_result),
      .rsp_truncated    (rsp_truncated)
   );

endmodule
